[sv/tmr_pkg.sv]
// ----------------------------------------------------------------------------
// tmr_pkg
// Shared types, codes and constants for the divider/counter timer block.
// ----------------------------------------------------------------------------
package tmr_pkg;

  // Item commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register selects
  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_CNT  = 2'd1;
  localparam logic [1:0] REG_MOD  = 2'd2;
  localparam logic [1:0] REG_CTRL = 2'd3;

  // Control byte fields
  localparam int unsigned CTRL_ENABLE_BIT = 2;
  localparam int unsigned CTRL_RATE_LSB   = 0;
  localparam int unsigned CTRL_RATE_MSB   = 1;

  // Widths
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned CYCLES_W    = 6;
  localparam int unsigned PRESCALE_W  = 9;
  localparam int unsigned COUNTDOWN_W = 12;

  // Prescaler wraps when the accumulated cycles reach this value
  localparam logic [PRESCALE_W:0] PRESCALE_LIMIT = (PRESCALE_W+1)'(255);

  // Countdown value after reset (rate select 0)
  localparam logic [COUNTDOWN_W-1:0] COUNTDOWN_RESET = COUNTDOWN_W'(1024);

  typedef struct packed {
    logic [1:0]          cmd;
    logic [1:0]          reg_select;
    logic [DATA_W-1:0]   write_data;
    logic [CYCLES_W-1:0] tick_cycles;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              timer_irq;
  } result_t;

  // Countdown period for each rate select
  function automatic logic [COUNTDOWN_W-1:0] rate_period(input logic [1:0] rate);
    logic [COUNTDOWN_W-1:0] p;
    unique case (rate)
      2'd0:    p = COUNTDOWN_W'(1024);
      2'd1:    p = COUNTDOWN_W'(16);
      2'd2:    p = COUNTDOWN_W'(64);
      default: p = COUNTDOWN_W'(256);
    endcase
    return p;
  endfunction

endpackage

[sv/tmr_if.sv]
// ----------------------------------------------------------------------------
// tmr_if
// Valid/ready channels carrying timer request items and result items.
// ----------------------------------------------------------------------------
interface tmr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] reg_select;
  logic [7:0] write_data;
  logic [5:0] tick_cycles;

  modport source (output valid, cmd, reg_select, write_data, tick_cycles, input ready);
  modport sink   (input valid, cmd, reg_select, write_data, tick_cycles, output ready);
endinterface

interface tmr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       timer_irq;

  modport source (output valid, read_data, timer_irq, input ready);
  modport sink   (input valid, read_data, timer_irq, output ready);
endinterface

[sv/tmr_in_reg.sv]
// ----------------------------------------------------------------------------
// tmr_in_reg
// Input register: captures one request item and holds it until the core
// consumes it.
// ----------------------------------------------------------------------------
module tmr_in_reg
  import tmr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  held_valid,
  input  logic  held_take,
  output item_t held_item
);

  logic  valid;
  item_t item;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready   = !valid || held_take;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

[sv/tmr_core.sv]
// ----------------------------------------------------------------------------
// tmr_core
// Timer state registers and next-state logic for one item per cycle on fire:
// divider/prescaler, period countdown, counter, reload and control bytes.
// ----------------------------------------------------------------------------
module tmr_core
  import tmr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  logic [DATA_W-1:0]      divider_value,    divider_value_next;
  logic [PRESCALE_W-1:0]  divider_prescale, divider_prescale_next;
  logic [COUNTDOWN_W-1:0] period_countdown, period_countdown_next;
  logic [DATA_W-1:0]      count_value,      count_value_next;
  logic [DATA_W-1:0]      reload_value,     reload_value_next;
  logic [DATA_W-1:0]      control_byte,     control_byte_next;

  logic [PRESCALE_W:0]    pre_sum;
  logic [COUNTDOWN_W-1:0] cycles_ext;
  logic [1:0]             new_rate;

  assign pre_sum    = {1'b0, divider_prescale} + (PRESCALE_W+1)'(item.tick_cycles);
  assign cycles_ext = COUNTDOWN_W'(item.tick_cycles);
  assign new_rate   = item.write_data[CTRL_RATE_MSB:CTRL_RATE_LSB];

  // Next state and result for the current item
  always_comb begin
    divider_value_next    = divider_value;
    divider_prescale_next = divider_prescale;
    period_countdown_next = period_countdown;
    count_value_next      = count_value;
    reload_value_next     = reload_value;
    control_byte_next     = control_byte;
    result                = '0;

    unique case (item.cmd)
      CMD_TICK: begin
        // prescaler and divider
        if (pre_sum >= PRESCALE_LIMIT) begin
          divider_prescale_next = '0;
          divider_value_next    = divider_value + DATA_W'(1);
        end else begin
          divider_prescale_next = pre_sum[PRESCALE_W-1:0];
        end
        // countdown and counter
        if (control_byte[CTRL_ENABLE_BIT]) begin
          if (cycles_ext >= period_countdown) begin
            period_countdown_next =
              rate_period(control_byte[CTRL_RATE_MSB:CTRL_RATE_LSB]);
            if (count_value == '1) begin
              count_value_next = reload_value;
              result.timer_irq = 1'b1;
            end else begin
              count_value_next = count_value + DATA_W'(1);
            end
          end else begin
            period_countdown_next = period_countdown - cycles_ext;
          end
        end
      end
      CMD_READ: begin
        unique case (item.reg_select)
          REG_DIV: result.read_data = divider_value;
          REG_CNT: result.read_data = count_value;
          REG_MOD: result.read_data = reload_value;
          default: result.read_data = control_byte;
        endcase
      end
      CMD_WRITE: begin
        unique case (item.reg_select)
          REG_DIV: divider_value_next = '0;
          REG_CNT: count_value_next   = item.write_data;
          REG_MOD: reload_value_next  = item.write_data;
          default: begin
            control_byte_next = item.write_data;
            // reload only when the rate select changes
            if (new_rate != control_byte[CTRL_RATE_MSB:CTRL_RATE_LSB]) begin
              period_countdown_next = rate_period(new_rate);
            end
          end
        endcase
      end
      default: begin
        // unused command: no change, zero result
      end
    endcase
  end

  // State update on each consumed item
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_value    <= '0;
      divider_prescale <= '0;
      period_countdown <= COUNTDOWN_RESET;
      count_value      <= '0;
      reload_value     <= '0;
      control_byte     <= '0;
    end else if (fire) begin
      divider_value    <= divider_value_next;
      divider_prescale <= divider_prescale_next;
      period_countdown <= period_countdown_next;
      count_value      <= count_value_next;
      reload_value     <= reload_value_next;
      control_byte     <= control_byte_next;
    end
  end

endmodule

[sv/div_tima_timer_peripheral.sv]
// ----------------------------------------------------------------------------
// div_tima_timer_peripheral
// Divider/counter timer with modulo reload and control byte. Each request
// item is a tick, a register read or a register write; each gives one result.
// Path: input register, then result register; the core takes the held item
// only when the result register is empty or its result is being taken.
// Throughput: one item per cycle while rsp.ready holds high.
// Reset: synchronous rst clears state and valid bits; countdown starts at 1024.
// ----------------------------------------------------------------------------
module div_tima_timer_peripheral
  import tmr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  tmr_req_if.sink   req,
  tmr_rsp_if.source rsp
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    fire;
  result_t result;
  result_t rsp_data;
  logic    rsp_valid;

  assign in_item = '{cmd: req.cmd, reg_select: req.reg_select,
                     write_data: req.write_data, tick_cycles: req.tick_cycles};

  // Core consumes the held item when the result register can take its result
  assign fire = held_valid && (!rsp_valid || rsp.ready);

  tmr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_take  (fire),
    .held_item  (held_item)
  );

  tmr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held_item),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_data.read_data;
  assign rsp.timer_irq = rsp_data.timer_irq;

endmodule
